>>> src/vertex_transform_4x4_defines.svh
// assertion macros shared by the vertex transform modules
`ifndef VERTEX_TRANSFORM_4X4_DEFINES_SVH
`define VERTEX_TRANSFORM_4X4_DEFINES_SVH

// same-cycle implication, checks suspended while in reset
`define VT4_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vertex transform check failed");

// next-cycle implication, checks suspended while in reset
`define VT4_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vertex transform check failed");

`endif

>>> src/vt4_pkg.sv
// shared types and constants for the 4x4 vertex transform
`default_nettype none
package vt4_pkg;

    localparam int VT4_FRAC_BITS = 16;
    localparam int VT4_DATA_W    = 32;
    localparam int VT4_PROD_W    = 64;
    localparam int VT4_PAIR_W    = 65;
    localparam int VT4_SUM_W     = 66;

    typedef enum logic {
        MODE_WRITE     = 1'b0,
        MODE_TRANSFORM = 1'b1
    } t_mode;

    typedef logic signed [VT4_DATA_W-1:0] t_word;
    typedef logic signed [VT4_PROD_W-1:0] t_prod;
    typedef logic signed [VT4_PAIR_W-1:0] t_pair;
    typedef logic signed [VT4_SUM_W-1:0]  t_sum;

    typedef struct packed {
        t_mode       mode;
        logic [3:0]  elem_index;
        t_word       elem_value;
        t_word       vec_x;
        t_word       vec_y;
        t_word       vec_z;
        t_word       vec_w;
    } t_vt4_in;

    typedef struct packed {
        t_word out_x;
        t_word out_y;
        t_word out_z;
        t_word out_w;
        logic  saturated;
    } t_vt4_out;

endpackage
`default_nettype wire

>>> src/vertex_transform_4x4.sv
// a transform beat passes the product, pair-sum, row-sum and output registers in turn; a stall can hold it
// throughput: one beat per cycle unless an output stall backs up the pipeline, writes and transforms mixed freely
// a matrix write takes effect at its accept edge and is seen by the very next beat
// the rate is set by the four-stage multiply, pair-add, row-add, saturate pipeline
// reset: synchronous active low, matrix back to identity, pipeline emptied
`default_nettype none
module vertex_transform_4x4 #(
    parameter int FRAC_BITS = vt4_pkg::VT4_FRAC_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire vt4_pkg::t_vt4_in  i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output vt4_pkg::t_vt4_out      o_out_data
);
    import vt4_pkg::*;

    logic [15:0][VT4_DATA_W-1:0] mat;
    logic [15:0][VT4_PROD_W-1:0] prod;
    logic [3:0][VT4_SUM_W-1:0]   sum;
    t_word                       vec [4];
    logic                        in_ready;
    logic                        in_accept;
    logic                        mul_valid;
    logic                        tree_ready;
    logic                        tree_valid;
    logic                        sat_ready;

    assign o_in_stall = !in_ready;
    assign in_accept  = i_in_valid && in_ready;

    assign vec[0] = i_in_data.vec_x;
    assign vec[1] = i_in_data.vec_y;
    assign vec[2] = i_in_data.vec_z;
    assign vec[3] = i_in_data.vec_w;

    vt4_matrix #(
        .FRAC_BITS (FRAC_BITS)
    ) u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (in_accept && (i_in_data.mode == MODE_WRITE)),
        .i_idx   (i_in_data.elem_index),
        .i_value (i_in_data.elem_value),
        .o_mat   (mat)
    );

    vt4_mul_array u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid && (i_in_data.mode == MODE_TRANSFORM)),
        .o_ready (in_ready),
        .i_mat   (mat),
        .i_vec   (vec),
        .o_valid (mul_valid),
        .i_ready (tree_ready),
        .o_prod  (prod)
    );

    vt4_add_tree u_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mul_valid),
        .o_ready (tree_ready),
        .i_prod  (prod),
        .o_valid (tree_valid),
        .i_ready (sat_ready),
        .o_sum   (sum)
    );

    vt4_sat_out #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (tree_valid),
        .o_ready (sat_ready),
        .i_sum   (sum),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule
`default_nettype wire

>>> src/vt4_matrix.sv
// row-major 4x4 matrix store, reset to identity
`default_nettype none
`include "vertex_transform_4x4_defines.svh"
module vt4_matrix #(
    parameter int FRAC_BITS = vt4_pkg::VT4_FRAC_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_we,
    input  wire logic [3:0]                  i_idx,
    input  wire vt4_pkg::t_word              i_value,
    output logic [15:0][vt4_pkg::VT4_DATA_W-1:0] o_mat
);
    import vt4_pkg::*;

    localparam logic [VT4_DATA_W-1:0] ONE = VT4_DATA_W'(1) << FRAC_BITS;

    logic [15:0][VT4_DATA_W-1:0] r_mat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_mat[i] <= (i % 5 == 0) ? ONE : '0;
            end
        end else if (i_we) begin
            r_mat[i_idx] <= i_value;
        end
    end

    assign o_mat = r_mat;

    `VT4_ASSERT_NEXT(a_write_lands, i_clk, i_rst_n, i_we, r_mat[$past(i_idx)] == $past(i_value))

endmodule
`default_nettype wire

>>> src/vt4_mul_array.sv
// first stage: sixteen 32x32 signed products
`default_nettype none
module vt4_mul_array (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [15:0][vt4_pkg::VT4_DATA_W-1:0] i_mat,
    input  wire vt4_pkg::t_word                  i_vec [4],
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [15:0][vt4_pkg::VT4_PROD_W-1:0] o_prod
);
    import vt4_pkg::*;

    logic                         r_v1;
    logic [15:0][VT4_PROD_W-1:0]  r_prod;
    t_prod                        n_prod [16];

    assign o_ready = !r_v1 || i_ready;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            n_prod[i] = $signed(i_mat[i]) * i_vec[i % 4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (o_ready) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            for (int i = 0; i < 16; i++) begin
                r_prod[i] <= n_prod[i];
            end
        end
    end

    assign o_valid = r_v1;
    assign o_prod  = r_prod;

endmodule
`default_nettype wire

>>> src/vt4_add_tree.sv
// second and third stages: pair sums, then exact row sums
`default_nettype none
`include "vertex_transform_4x4_defines.svh"
module vt4_add_tree (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [15:0][vt4_pkg::VT4_PROD_W-1:0] i_prod,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [3:0][vt4_pkg::VT4_SUM_W-1:0]   o_sum
);
    import vt4_pkg::*;

    logic                        r_v2;
    logic                        r_v3;
    logic [7:0][VT4_PAIR_W-1:0]  r_pair;
    logic [3:0][VT4_SUM_W-1:0]   r_sum;
    logic                        ready3;

    assign ready3  = !r_v3 || i_ready;
    assign o_ready = !r_v2 || ready3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (o_ready) begin
                r_v2 <= i_valid;
            end
            if (ready3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            for (int k = 0; k < 8; k++) begin
                r_pair[k] <= $signed({i_prod[2*k][VT4_PROD_W-1], i_prod[2*k]})
                           + $signed({i_prod[2*k+1][VT4_PROD_W-1], i_prod[2*k+1]});
            end
        end
        if (ready3 && r_v2) begin
            for (int r = 0; r < 4; r++) begin
                r_sum[r] <= $signed({r_pair[2*r][VT4_PAIR_W-1], r_pair[2*r]})
                          + $signed({r_pair[2*r+1][VT4_PAIR_W-1], r_pair[2*r+1]});
            end
        end
    end

    assign o_valid = r_v3;
    assign o_sum   = r_sum;

    // a held row sum must survive a downstream stall
    `VT4_ASSERT_NEXT(a_sum_holds, i_clk, i_rst_n, r_v3 && !i_ready, r_v3 && $stable(r_sum))
    `VT4_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, r_v2 && r_v3 && !i_ready, !o_ready)

endmodule
`default_nettype wire

>>> src/vt4_sat_out.sv
// fourth stage: floor shift, saturation and the output register
`default_nettype none
`include "vertex_transform_4x4_defines.svh"
module vt4_sat_out #(
    parameter int FRAC_BITS = vt4_pkg::VT4_FRAC_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [3:0][vt4_pkg::VT4_SUM_W-1:0] i_sum,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output vt4_pkg::t_vt4_out                  o_data
);
    import vt4_pkg::*;

    localparam t_sum  SUM_MAX = $signed({{(VT4_SUM_W-31){1'b0}}, {31{1'b1}}});
    localparam t_sum  SUM_MIN = $signed({{(VT4_SUM_W-31){1'b1}}, {31{1'b0}}});
    localparam t_word W_MAX   = $signed({1'b0, {31{1'b1}}});
    localparam t_word W_MIN   = $signed({1'b1, {31{1'b0}}});

    logic     r_v4;
    t_vt4_out r_out;
    t_word    n_comp [4];
    logic     n_clip;
    t_sum     sh;

    assign o_ready = !r_v4 || !i_stall;

    always_comb begin
        n_clip = 1'b0;
        sh     = '0;
        for (int r = 0; r < 4; r++) begin
            // arithmetic shift is floor division by the fraction scale
            sh = $signed(i_sum[r]) >>> FRAC_BITS;
            if (sh > SUM_MAX) begin
                n_comp[r] = W_MAX;
                n_clip    = 1'b1;
            end else if (sh < SUM_MIN) begin
                n_comp[r] = W_MIN;
                n_clip    = 1'b1;
            end else begin
                n_comp[r] = sh[VT4_DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (o_ready) begin
            r_v4 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_out.out_x     <= n_comp[0];
            r_out.out_y     <= n_comp[1];
            r_out.out_z     <= n_comp[2];
            r_out.out_w     <= n_comp[3];
            r_out.saturated <= n_clip;
        end
    end

    assign o_valid = r_v4;
    assign o_data  = r_out;

    `VT4_ASSERT_NOW(a_clip_flag, i_clk, i_rst_n, r_v4 && r_out.saturated, r_out.out_x == W_MAX || r_out.out_x == W_MIN || r_out.out_y == W_MAX || r_out.out_y == W_MIN || r_out.out_z == W_MAX || r_out.out_z == W_MIN || r_out.out_w == W_MAX || r_out.out_w == W_MIN)

endmodule
`default_nettype wire
